/* hdl/besc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// besc_pkg
// Shared types and codes for the BER end-of-contents scanner.
// ----------------------------------------------------------------------------
package besc_pkg;

	// Result status codes
	localparam logic [3:0] ST_HDR_BYTE   = 4'd0;
	localparam logic [3:0] ST_HDR_DONE   = 4'd1;
	localparam logic [3:0] ST_CONTENT    = 4'd2;
	localparam logic [3:0] ST_FINISHED   = 4'd3;
	localparam logic [3:0] ST_IDLE       = 4'd4;
	localparam logic [3:0] ST_EOC_LEN    = 4'd5;
	localparam logic [3:0] ST_INDEF_PRIM = 4'd6;
	localparam logic [3:0] ST_LONG_LEN   = 4'd7;
	localparam logic [3:0] ST_NEST_OVF   = 4'd8;

	// Identifier and length octet constants
	localparam logic [4:0] TAG_LONG_FORM  = 5'h1f;
	localparam logic [7:0] LEN_INDEFINITE = 8'h80;

	typedef enum logic [5:0] {
		PH_IDLE     = 6'b000001,
		PH_TAG      = 6'b000010,
		PH_TAG_LONG = 6'b000100,
		PH_LEN      = 6'b001000,
		PH_LEN_LONG = 6'b010000,
		PH_CONTENT  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] tag_number;
		logic [1:0]  tag_class;
		logic        constructed;
		logic        indefinite;
		logic [63:0] content_length;
		logic [15:0] nesting_depth;
		logic [63:0] byte_position;
	} besc_result_t;

endpackage
`default_nettype wire

/* hdl/besc_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// besc_parser
// Scanner state and the per-byte step: tag, length and content parsing.
// ----------------------------------------------------------------------------
module besc_parser import besc_pkg::*; #(
	parameter int NEST_WIDTH       = 16,
	parameter int MAX_LENGTH_BYTES = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   data_byte,
	input  wire logic         begin_req,
	output besc_result_t      result
);

	phase_t                  phase_q, phase_d;
	logic [31:0]             tag_q, tag_d;
	logic [2:0]              flags_q, flags_d;
	logic [63:0]             len_q, len_d;
	logic [3:0]              len_left_q, len_left_d;
	logic [63:0]             content_left_q, content_left_d;
	logic [NEST_WIDTH-1:0]   nest_q, nest_d;
	logic [63:0]             offset_q, offset_d;
	logic                    indef_q, indef_d;
	logic [3:0]              status;
	logic                    hdr_done;
	logic [63:0]             nest_ext;

	always_comb begin
		phase_d        = phase_q;
		tag_d          = tag_q;
		flags_d        = flags_q;
		len_d          = len_q;
		len_left_d     = len_left_q;
		content_left_d = content_left_q;
		nest_d         = nest_q;
		offset_d       = offset_q;
		indef_d        = indef_q;
		status         = ST_IDLE;
		hdr_done       = 1'b0;

		// Restart abandons any scan in progress
		if (begin_req) begin
			phase_d        = PH_TAG;
			nest_d         = NEST_WIDTH'(1);
			tag_d          = '0;
			flags_d        = '0;
			len_d          = '0;
			len_left_d     = '0;
			content_left_d = '0;
			indef_d        = 1'b0;
		end

		if (phase_d != PH_IDLE) begin
			offset_d = offset_q + 64'd1;
			case (phase_d)
				PH_TAG: begin
					flags_d = data_byte[7:5];
					len_d   = '0;
					indef_d = 1'b0;
					if (data_byte[4:0] == TAG_LONG_FORM) begin
						tag_d   = '0;
						phase_d = PH_TAG_LONG;
					end else begin
						tag_d   = {27'd0, data_byte[4:0]};
						phase_d = PH_LEN;
					end
					status = ST_HDR_BYTE;
				end
				PH_TAG_LONG: begin
					tag_d = {tag_d[24:0], data_byte[6:0]};
					if (!data_byte[7])
						phase_d = PH_LEN;
					status = ST_HDR_BYTE;
				end
				PH_LEN: begin
					if (data_byte == LEN_INDEFINITE) begin
						indef_d  = 1'b1;
						len_d    = '0;
						hdr_done = 1'b1;
					end else if (!data_byte[7]) begin
						len_d    = {56'd0, data_byte};
						hdr_done = 1'b1;
					end else if (data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
						phase_d = PH_IDLE;
						status  = ST_LONG_LEN;
					end else begin
						len_left_d = data_byte[3:0];
						len_d      = '0;
						phase_d    = PH_LEN_LONG;
						status     = ST_HDR_BYTE;
					end
				end
				PH_LEN_LONG: begin
					len_d = {len_d[55:0], data_byte};
					if (len_left_d != 4'd0)
						len_left_d = len_left_d - 4'd1;
					if (len_left_d == 4'd0)
						hdr_done = 1'b1;
					else
						status = ST_HDR_BYTE;
				end
				PH_CONTENT: begin
					if (content_left_d != 64'd0)
						content_left_d = content_left_d - 64'd1;
					if (content_left_d == 64'd0)
						phase_d = PH_TAG;
					status = ST_CONTENT;
				end
				default: begin
					phase_d = PH_IDLE;
					status  = ST_IDLE;
				end
			endcase
		end

		// Act on a completed header
		if (hdr_done) begin
			status = ST_HDR_DONE;
			if (tag_d == 32'd0) begin
				if (indef_d || len_d != 64'd0) begin
					phase_d = PH_IDLE;
					status  = ST_EOC_LEN;
				end else begin
					if (nest_d != '0)
						nest_d = nest_d - NEST_WIDTH'(1);
					if (nest_d == '0) begin
						phase_d = PH_IDLE;
						status  = ST_FINISHED;
					end else begin
						phase_d = PH_TAG;
					end
				end
			end else if (indef_d) begin
				if (!flags_d[0]) begin
					phase_d = PH_IDLE;
					status  = ST_INDEF_PRIM;
				end else if (&nest_d) begin
					phase_d = PH_IDLE;
					status  = ST_NEST_OVF;
				end else begin
					nest_d  = nest_d + NEST_WIDTH'(1);
					phase_d = PH_TAG;
				end
			end else if (len_d == 64'd0) begin
				phase_d = PH_TAG;
			end else begin
				content_left_d = len_d;
				phase_d        = PH_CONTENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			tag_q          <= '0;
			flags_q        <= '0;
			len_q          <= '0;
			len_left_q     <= '0;
			content_left_q <= '0;
			nest_q         <= '0;
			offset_q       <= '0;
			indef_q        <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			tag_q          <= tag_d;
			flags_q        <= flags_d;
			len_q          <= len_d;
			len_left_q     <= len_left_d;
			content_left_q <= content_left_d;
			nest_q         <= nest_d;
			offset_q       <= offset_d;
			indef_q        <= indef_d;
		end
	end

	assign nest_ext = 64'(nest_d);

	always_comb begin
		result.status         = status;
		result.tag_number     = tag_d;
		result.tag_class      = flags_d[2:1];
		result.constructed    = flags_d[0];
		result.indefinite     = indef_d;
		result.content_length = len_d;
		result.nesting_depth  = nest_ext[15:0];
		result.byte_position  = offset_d;
	end

endmodule
`default_nettype wire

/* hdl/ber_skip_to_end_of_contents_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted byte is held in the input register; the scanner state
//   updates in a single pass as its result enters the result register.
// Throughput: one byte per cycle while out_ready does not stall the output.
// Reset: arst_n clears the scanner to idle with all counters at zero.
// ----------------------------------------------------------------------------
// ber_skip_to_end_of_contents_top
// BER byte-stream scanner that skips to the matching end-of-contents.
// ----------------------------------------------------------------------------
module ber_skip_to_end_of_contents_top import besc_pkg::*; #(
	parameter int NEST_WIDTH       = 16,
	parameter int MAX_LENGTH_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        begin_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [31:0]      tag_number,
	output logic [1:0]       tag_class,
	output logic             constructed,
	output logic             indefinite,
	output logic [63:0]      content_length,
	output logic [15:0]      nesting_depth,
	output logic [63:0]      byte_position
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         begin_s1;
	logic         advance;
	besc_result_t res;
	besc_result_t result_q;
	logic         out_valid_q;

	// Move the staged byte into the result register when it is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			begin_s1 <= begin_req;
		end
	end

	besc_parser #(
		.NEST_WIDTH       (NEST_WIDTH),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.begin_req (begin_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign status         = result_q.status;
	assign tag_number     = result_q.tag_number;
	assign tag_class      = result_q.tag_class;
	assign constructed    = result_q.constructed;
	assign indefinite     = result_q.indefinite;
	assign content_length = result_q.content_length;
	assign nesting_depth  = result_q.nesting_depth;
	assign byte_position  = result_q.byte_position;

endmodule
`default_nettype wire

/* hdl/besc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// besc_checker
// Port-level checks for the BER end-of-contents scanner.
// ----------------------------------------------------------------------------
module besc_checker import besc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        begin_req,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [3:0]  status,
	input  wire logic [31:0] tag_number,
	input  wire logic [1:0]  tag_class,
	input  wire logic        constructed,
	input  wire logic        indefinite,
	input  wire logic [63:0] content_length,
	input  wire logic [15:0] nesting_depth,
	input  wire logic [63:0] byte_position
);

	// Hold an input transaction offered but not yet taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte)
			&& $stable(begin_req))
		else $error("input changed while stalled");

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_position)
			&& $stable(status))
		else $error("result changed while stalled");

	a_finish_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FINISHED |-> nesting_depth == 16'd0
			&& tag_number == 32'd0 && !indefinite)
		else $error("finish with open nesting");

	a_eoc_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EOC_LEN |-> tag_number == 32'd0
			&& (indefinite || content_length != 64'd0))
		else $error("bad end-of-contents length report");

	a_indef_prim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INDEF_PRIM |-> indefinite && !constructed)
		else $error("indefinite primitive report inconsistent");

endmodule

bind ber_skip_to_end_of_contents_top besc_checker u_besc_checker (.*);
`default_nettype wire
